>>> sv/sfpe_pkg.sv
// shared types and constants for the spi flash program / erase sequencer
// no dependencies; used by every other file of the block

package sfpe_pkg;

  localparam int unsigned AddrW  = 24;
  localparam int unsigned LenW   = 16;
  localparam int unsigned MaxRes = 7;
  localparam int unsigned CountW = 3;

  // host request codes
  typedef enum logic [1:0] {
    OpProgStart = 2'd0,
    OpProgData  = 2'd1,
    OpErase     = 2'd2,
    OpStatus    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhData = 3'b010,
    PhPoll = 3'b100
  } phase_e;

  // flash command bytes
  localparam logic [7:0] CmdWren  = 8'h06;
  localparam logic [7:0] CmdWrdi  = 8'h04;
  localparam logic [7:0] CmdRdsr  = 8'h05;
  localparam logic [7:0] CmdDummy = 8'hFF;
  localparam logic [7:0] CmdPp    = 8'h02;
  localparam logic [7:0] CmdSe    = 8'h20;
  localparam logic [7:0] BusyMask = 8'h01;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
    logic [LenW-1:0]  length;
    logic [7:0]       data_byte;
    logic [7:0]       status_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] mosi;
    logic       end_sel;
    logic       reply;
    logic       done;
  } entry_t;

  typedef struct packed {
    entry_t [MaxRes-1:0] entries;
    logic [CountW-1:0]   count;
  } burst_t;

  function automatic entry_t mk_entry(logic [7:0] b, logic e, logic r, logic d);
    entry_t t;
    t.mosi    = b;
    t.end_sel = e;
    t.reply   = r;
    t.done    = d;
    return t;
  endfunction

endpackage

>>> sv/sfpe_if.sv
// valid/ready channel interfaces for host requests and spi byte frames
// depends on sfpe_pkg for field widths

interface sfpe_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [sfpe_pkg::AddrW-1:0]  address;
  logic [sfpe_pkg::LenW-1:0]   length;
  logic [7:0]                  data_byte;
  logic [7:0]                  status_byte;

  modport source (output valid, operation, address, length, data_byte, status_byte,
                  input ready);
  modport sink (input valid, operation, address, length, data_byte, status_byte,
                output ready);
endinterface

interface sfpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mosi_byte;
  logic       end_select;
  logic       reply_expected;
  logic       op_done;
  logic       last;

  modport source (output valid, mosi_byte, end_select, reply_expected, op_done, last,
                  input ready);
  modport sink (input valid, mosi_byte, end_select, reply_expected, op_done, last,
                output ready);
endinterface

>>> sv/sfpe_page_rem.sv
// input register and two-stage page offset pipeline (address mod page size)
// depends on sfpe_pkg

module sfpe_page_rem #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  sfpe_pkg::item_t                      item_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output sfpe_pkg::item_t                      item_o,
  output logic [$clog2(PAGE_BYTES)-1:0]        rem_o
);

  localparam int unsigned AddrW = sfpe_pkg::AddrW;
  localparam int unsigned RemW  = $clog2(PAGE_BYTES);
  localparam int unsigned CntW  = $clog2(PAGE_BYTES + 1);
  localparam int unsigned Recip = (1 << AddrW) / PAGE_BYTES;
  localparam int unsigned RecW  = $clog2(Recip + 1);

  logic v1_q, v2_q, v3_q;
  logic r1, r2, r3;
  sfpe_pkg::item_t it1_q, it2_q, it3_q;
  logic [RecW-1:0] quo_d, quo_q;
  logic [RemW-1:0] rem_d, rem_q;
  logic [AddrW+RecW-1:0] prod;
  logic [RecW+CntW-1:0]  qp;
  logic [RemW:0]         diff;

  assign r3 = !v3_q || ready_i;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign ready_o = r1;

  // quotient estimate by reciprocal, may fall one short
  assign prod  = (AddrW+RecW)'(it1_q.address) * (AddrW+RecW)'(Recip);
  assign quo_d = prod[AddrW+RecW-1:AddrW];

  // remainder lies below twice the page size, one correction
  assign qp   = (RecW+CntW)'(quo_q) * (RecW+CntW)'(PAGE_BYTES);
  assign diff = it2_q.address[RemW:0] - qp[RemW:0];
  always_comb begin
    if (diff >= (RemW+1)'(PAGE_BYTES)) begin
      rem_d = RemW'(diff - (RemW+1)'(PAGE_BYTES));
    end else begin
      rem_d = diff[RemW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) it1_q <= item_i;
    if (r2) begin
      it2_q <= it1_q;
      quo_q <= quo_d;
    end
    if (r3) begin
      it3_q <= it2_q;
      rem_q <= rem_d;
    end
  end

  assign valid_o = v3_q;
  assign item_o  = it3_q;
  assign rem_o   = rem_q;

endmodule

>>> sv/sfpe_decode.sv
// command decoder: builds the byte burst and next state for one request
// depends on sfpe_pkg

module sfpe_decode #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  sfpe_pkg::phase_e                    phase_i,
  input  logic [$clog2(PAGE_BYTES+1)-1:0]     bytes_left_i,
  input  sfpe_pkg::item_t                     item_i,
  input  logic [$clog2(PAGE_BYTES)-1:0]       rem_i,
  output sfpe_pkg::burst_t                    burst_o,
  output sfpe_pkg::phase_e                    phase_o,
  output logic [$clog2(PAGE_BYTES+1)-1:0]     bytes_left_o
);

  localparam int unsigned CntW = $clog2(PAGE_BYTES + 1);
  localparam int unsigned LenW = sfpe_pkg::LenW;

  logic [CntW-1:0] remain;
  logic [CntW-1:0] clipped;
  logic [CntW-1:0] bl_dec;
  logic            clip_zero;
  logic [7:0]      opc;

  // bytes left in the page, never zero
  assign remain  = CntW'(PAGE_BYTES) - CntW'(rem_i);
  assign clipped = (item_i.length > LenW'(remain)) ? remain : item_i.length[CntW-1:0];
  assign clip_zero = (clipped == '0);
  assign bl_dec  = (bytes_left_i != '0) ? bytes_left_i - CntW'(1) : '0;
  assign opc     = (item_i.operation == sfpe_pkg::OpErase) ? sfpe_pkg::CmdSe
                                                           : sfpe_pkg::CmdPp;

  always_comb begin
    burst_o      = '0;
    phase_o      = phase_i;
    bytes_left_o = bytes_left_i;
    unique case (phase_i)
      sfpe_pkg::PhIdle: begin
        if (item_i.operation == sfpe_pkg::OpProgStart ||
            item_i.operation == sfpe_pkg::OpErase) begin
          burst_o.entries[0] = sfpe_pkg::mk_entry(sfpe_pkg::CmdWren, 1'b1, 1'b0, 1'b0);
          burst_o.entries[1] = sfpe_pkg::mk_entry(opc, 1'b0, 1'b0, 1'b0);
          burst_o.entries[2] = sfpe_pkg::mk_entry(item_i.address[23:16], 1'b0, 1'b0, 1'b0);
          burst_o.entries[3] = sfpe_pkg::mk_entry(item_i.address[15:8], 1'b0, 1'b0, 1'b0);
          if (item_i.operation == sfpe_pkg::OpProgStart && !clip_zero) begin
            burst_o.entries[4] = sfpe_pkg::mk_entry(item_i.address[7:0], 1'b0, 1'b0, 1'b0);
            burst_o.count      = sfpe_pkg::CountW'(5);
            phase_o            = sfpe_pkg::PhData;
            bytes_left_o       = clipped;
          end else begin
            // erase, or a program with nothing to send: straight to polling
            burst_o.entries[4] = sfpe_pkg::mk_entry(item_i.address[7:0], 1'b1, 1'b0, 1'b0);
            burst_o.entries[5] = sfpe_pkg::mk_entry(sfpe_pkg::CmdRdsr, 1'b0, 1'b0, 1'b0);
            burst_o.entries[6] = sfpe_pkg::mk_entry(sfpe_pkg::CmdDummy, 1'b1, 1'b1, 1'b0);
            burst_o.count      = sfpe_pkg::CountW'(7);
            phase_o            = sfpe_pkg::PhPoll;
          end
        end
      end
      sfpe_pkg::PhData: begin
        if (item_i.operation == sfpe_pkg::OpProgData) begin
          bytes_left_o = bl_dec;
          if (bl_dec == '0) begin
            burst_o.entries[0] = sfpe_pkg::mk_entry(item_i.data_byte, 1'b1, 1'b0, 1'b0);
            burst_o.entries[1] = sfpe_pkg::mk_entry(sfpe_pkg::CmdRdsr, 1'b0, 1'b0, 1'b0);
            burst_o.entries[2] = sfpe_pkg::mk_entry(sfpe_pkg::CmdDummy, 1'b1, 1'b1, 1'b0);
            burst_o.count      = sfpe_pkg::CountW'(3);
            phase_o            = sfpe_pkg::PhPoll;
          end else begin
            burst_o.entries[0] = sfpe_pkg::mk_entry(item_i.data_byte, 1'b0, 1'b0, 1'b0);
            burst_o.count      = sfpe_pkg::CountW'(1);
          end
        end
      end
      sfpe_pkg::PhPoll: begin
        if (item_i.operation == sfpe_pkg::OpStatus) begin
          if ((item_i.status_byte & sfpe_pkg::BusyMask) != 8'h00) begin
            burst_o.entries[0] = sfpe_pkg::mk_entry(sfpe_pkg::CmdRdsr, 1'b0, 1'b0, 1'b0);
            burst_o.entries[1] = sfpe_pkg::mk_entry(sfpe_pkg::CmdDummy, 1'b1, 1'b1, 1'b0);
            burst_o.count      = sfpe_pkg::CountW'(2);
          end else begin
            burst_o.entries[0] = sfpe_pkg::mk_entry(sfpe_pkg::CmdWrdi, 1'b1, 1'b0, 1'b1);
            burst_o.count      = sfpe_pkg::CountW'(1);
            phase_o            = sfpe_pkg::PhIdle;
            bytes_left_o       = '0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/sfpe_burst.sv
// result register: holds one byte burst and hands it out one frame per transfer
// depends on sfpe_pkg and sfpe_out_if

module sfpe_burst (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  output logic              load_ready_o,
  input  sfpe_pkg::burst_t  burst_i,
  sfpe_out_if.source        rsp
);

  logic                            busy_q;
  logic [sfpe_pkg::CountW-1:0]     idx_q;
  logic [sfpe_pkg::CountW-1:0]     count_q;
  sfpe_pkg::entry_t [sfpe_pkg::MaxRes-1:0] entries_q;
  logic xfer, at_last, load;
  sfpe_pkg::entry_t cur;

  assign cur     = entries_q[idx_q];
  assign at_last = (idx_q == count_q - sfpe_pkg::CountW'(1));
  assign xfer    = busy_q && rsp.ready;
  assign load_ready_o = !busy_q || (xfer && at_last);
  assign load    = load_valid_i && load_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load) begin
      busy_q <= (burst_i.count != '0);
      idx_q  <= '0;
    end else if (xfer) begin
      busy_q <= !at_last;
      idx_q  <= idx_q + sfpe_pkg::CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      entries_q <= burst_i.entries;
      count_q   <= burst_i.count;
    end
  end

  assign rsp.valid          = busy_q;
  assign rsp.mosi_byte      = cur.mosi;
  assign rsp.end_select     = cur.end_sel;
  assign rsp.reply_expected = cur.reply;
  assign rsp.op_done        = cur.done;
  assign rsp.last           = at_last;

endmodule

>>> sv/spi_flash_program_erase_sequencer.sv
// top level of the spi flash program / erase sequencer
// depends on sfpe_pkg, sfpe_if, sfpe_page_rem, sfpe_decode and sfpe_burst

// A request is taken into an input register, passes two stages that work out its
// offset within the flash page, and is then decoded against the sequencer state
// into a burst of one to seven spi byte frames (or none, when the request does not
// fit the current phase). The burst sits in the result register and leaves one frame
// per output transfer, so a request occupies the output for as many transfers as it
// has frames. The three pipeline registers keep taking requests while the result
// register drains and stall the input once they are full. A request that gives no
// frame is still loaded into the result register but sends nothing. A request passes
// the input register, both offset stages and the result register before its first
// frame. The sustained rate is set by the output port: one frame per cycle while ready.

module spi_flash_program_erase_sequencer #(
  parameter int unsigned PAGE_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfpe_in_if.sink     req_i,
  sfpe_out_if.source  rsp_o
);

  localparam int unsigned RemW = $clog2(PAGE_BYTES);
  localparam int unsigned CntW = $clog2(PAGE_BYTES + 1);

  sfpe_pkg::item_t  item_in, item_dec;
  sfpe_pkg::burst_t burst;
  sfpe_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  bytes_left_q, bytes_left_d;
  logic [RemW-1:0]  rem;
  logic             dec_valid, load_ready, adv;

  assign item_in.operation   = req_i.operation;
  assign item_in.address     = req_i.address;
  assign item_in.length      = req_i.length;
  assign item_in.data_byte   = req_i.data_byte;
  assign item_in.status_byte = req_i.status_byte;

  sfpe_page_rem #(.PAGE_BYTES(PAGE_BYTES)) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .ready_o (req_i.ready),
    .item_i  (item_in),
    .valid_o (dec_valid),
    .ready_i (load_ready),
    .item_o  (item_dec),
    .rem_o   (rem)
  );

  sfpe_decode #(.PAGE_BYTES(PAGE_BYTES)) u_dec (
    .phase_i      (phase_q),
    .bytes_left_i (bytes_left_q),
    .item_i       (item_dec),
    .rem_i        (rem),
    .burst_o      (burst),
    .phase_o      (phase_d),
    .bytes_left_o (bytes_left_d)
  );

  sfpe_burst u_burst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (dec_valid),
    .load_ready_o (load_ready),
    .burst_i      (burst),
    .rsp          (rsp_o)
  );

  // state moves on only when the decoded burst is handed over
  assign adv = dec_valid && load_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= sfpe_pkg::PhIdle;
      bytes_left_q <= '0;
    end else if (adv) begin
      phase_q      <= phase_d;
      bytes_left_q <= bytes_left_d;
    end
  end

  a_data_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == sfpe_pkg::PhData |-> bytes_left_q != '0)
    else $error("data phase with no bytes left");

  a_bytes_in_page : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_left_q <= CntW'(PAGE_BYTES))
    else $error("byte count beyond page size");

  a_done_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.op_done |-> rsp_o.end_select && rsp_o.last)
    else $error("completion frame not final");

  a_done_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.op_done |-> phase_q == sfpe_pkg::PhIdle)
    else $error("completion sent while not idle");

  a_drain_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.ready && rsp_o.last && !dec_valid |=> !rsp_o.valid)
    else $error("frames after the last of a burst");

endmodule

>>> tb/spi_flash_program_erase_sequencer_test.sv
// self-checking regression for the spi flash program / erase sequencer: drives host
// requests, predicts the spi byte frames of each one and compares them as they leave
// depends on sfpe_pkg, sfpe_if and spi_flash_program_erase_sequencer

typedef struct packed {
  logic [7:0] mosi;
  logic       end_sel;
  logic       reply;
  logic       done;
  logic       last;
} frame_t;

// keeps its own copy of the sequencer state and the frames still owed
class frame_predictor;
  int unsigned       page_bytes;
  sfpe_pkg::phase_e  phase;
  logic [8:0]        bytes_left;
  frame_t            frames_due[$];
  int unsigned       errors;

  function new(int unsigned page);
    page_bytes = page;
    phase      = sfpe_pkg::PhIdle;
    bytes_left = '0;
    errors     = 0;
  endfunction

  function void push_frame(logic [7:0] b, logic e, logic r, logic d);
    frame_t f;
    f.mosi    = b;
    f.end_sel = e;
    f.reply   = r;
    f.done    = d;
    f.last    = 1'b0;
    frames_due.push_back(f);
  endfunction

  function void push_status_read();
    push_frame(sfpe_pkg::CmdRdsr, 1'b0, 1'b0, 1'b0);
    push_frame(sfpe_pkg::CmdDummy, 1'b1, 1'b1, 1'b0);
  endfunction

  function void push_command(logic [7:0] cmd, logic [23:0] addr, logic end_sel);
    push_frame(sfpe_pkg::CmdWren, 1'b1, 1'b0, 1'b0);
    push_frame(cmd, 1'b0, 1'b0, 1'b0);
    push_frame(addr[23:16], 1'b0, 1'b0, 1'b0);
    push_frame(addr[15:8], 1'b0, 1'b0, 1'b0);
    push_frame(addr[7:0], end_sel, 1'b0, 1'b0);
  endfunction

  // returns how many frames the request causes
  function int unsigned take_request(sfpe_pkg::item_t it);
    int unsigned first;
    int unsigned remain;
    int unsigned clipped;
    first = frames_due.size();
    if (phase == sfpe_pkg::PhIdle && it.operation == sfpe_pkg::OpProgStart) begin
      remain  = page_bytes - (it.address % page_bytes);
      clipped = it.length;
      if (clipped > page_bytes) clipped = page_bytes;
      if (clipped > remain) clipped = remain;
      push_command(sfpe_pkg::CmdPp, it.address, clipped == 0);
      if (clipped == 0) begin
        push_status_read();
        phase = sfpe_pkg::PhPoll;
      end else begin
        bytes_left = clipped[8:0];
        phase      = sfpe_pkg::PhData;
      end
    end else if (phase == sfpe_pkg::PhData && it.operation == sfpe_pkg::OpProgData) begin
      if (bytes_left > 0) bytes_left--;
      if (bytes_left == 0) begin
        push_frame(it.data_byte, 1'b1, 1'b0, 1'b0);
        push_status_read();
        phase = sfpe_pkg::PhPoll;
      end else begin
        push_frame(it.data_byte, 1'b0, 1'b0, 1'b0);
      end
    end else if (phase == sfpe_pkg::PhIdle && it.operation == sfpe_pkg::OpErase) begin
      push_command(sfpe_pkg::CmdSe, it.address, 1'b1);
      push_status_read();
      phase = sfpe_pkg::PhPoll;
    end else if (phase == sfpe_pkg::PhPoll && it.operation == sfpe_pkg::OpStatus) begin
      if ((it.status_byte & sfpe_pkg::BusyMask) != 0) begin
        push_status_read();
      end else begin
        push_frame(sfpe_pkg::CmdWrdi, 1'b1, 1'b0, 1'b1);
        phase      = sfpe_pkg::PhIdle;
        bytes_left = '0;
      end
    end
    if (frames_due.size() > first) frames_due[frames_due.size()-1].last = 1'b1;
    return frames_due.size() - first;
  endfunction

  function void match_frame(frame_t got);
    frame_t want;
    if (frames_due.size() == 0) begin
      $error("unexpected frame: mosi_byte %h", got.mosi);
      errors++;
      return;
    end
    want = frames_due.pop_front();
    if (got.mosi !== want.mosi) begin
      $error("mosi_byte: expected %h actual %h", want.mosi, got.mosi);
      errors++;
    end
    if (got.end_sel !== want.end_sel) begin
      $error("end_select: expected %b actual %b", want.end_sel, got.end_sel);
      errors++;
    end
    if (got.reply !== want.reply) begin
      $error("reply_expected: expected %b actual %b", want.reply, got.reply);
      errors++;
    end
    if (got.done !== want.done) begin
      $error("op_done: expected %b actual %b", want.done, got.done);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %b actual %b", want.last, got.last);
      errors++;
    end
  endfunction
endclass

module spi_flash_program_erase_sequencer_test;

  localparam int unsigned PageBytes   = 256;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RoundItems  = 85;
  localparam int unsigned HoldOff     = 400;

  logic clk_i;
  logic rst_ni;

  sfpe_in_if  req_if();
  sfpe_out_if rsp_if();

  frame_predictor predictor;
  int unsigned    src_idle_pct;
  int unsigned    snk_idle_pct;
  int unsigned    hold_off;
  int unsigned    productive;
  int unsigned    cycles;

  spi_flash_program_erase_sequencer #(
    .PAGE_BYTES(PageBytes)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic sfpe_pkg::item_t request(sfpe_pkg::op_e op, logic [23:0] addr,
                                              logic [15:0] len, logic [7:0] db,
                                              logic [7:0] st);
    sfpe_pkg::item_t it;
    it.operation   = op;
    it.address     = addr;
    it.length      = len;
    it.data_byte   = db;
    it.status_byte = st;
    return it;
  endfunction

  function automatic sfpe_pkg::item_t rand_item(sfpe_pkg::op_e op);
    return request(op, 24'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // one request transfer, with random idle cycles ahead of it
  task automatic send_item(input sfpe_pkg::item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= it.operation;
    req_if.address     <= it.address;
    req_if.length      <= it.length;
    req_if.data_byte   <= it.data_byte;
    req_if.status_byte <= it.status_byte;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (predictor.take_request(it) > 0) productive++;
  endtask

  // feeds data bytes with some stray requests, up to two surplus ones, then status until the flash is ready
  task automatic complete_sequence();
    sfpe_pkg::item_t it;
    while (predictor.phase == sfpe_pkg::PhData) begin
      if ($urandom_range(19) == 0) begin
        send_item(rand_item(sfpe_pkg::op_e'($urandom_range(3))));
      end else begin
        send_item(rand_item(sfpe_pkg::OpProgData));
      end
    end
    repeat ($urandom_range(2)) send_item(rand_item(sfpe_pkg::OpProgData));
    while (predictor.phase == sfpe_pkg::PhPoll) begin
      it = rand_item(sfpe_pkg::OpStatus);
      it.status_byte[0] = ($urandom_range(2) != 0);
      send_item(it);
    end
  endtask

  task automatic run_program(input logic [23:0] addr, input logic [15:0] len);
    send_item(request(sfpe_pkg::OpProgStart, addr, len, 8'($urandom), 8'($urandom)));
    complete_sequence();
  endtask

  task automatic random_round(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned goal;
    logic [23:0] addr;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    goal = productive + RoundItems;
    while (productive < goal) begin
      addr = 24'($urandom);
      case ($urandom_range(9)) inside
        [0:1]: run_program(addr, 16'($urandom_range(0, 8)));
        2: run_program(addr, 16'($urandom_range(1, 20)));
        // large lengths land near the page end so the remainder keeps them short
        3: run_program({addr[23:8], 8'($urandom_range(240, 255))}, 16'($urandom));
        [4:6]: begin
          send_item(rand_item(sfpe_pkg::OpErase));
          complete_sequence();
        end
        default: begin
          // stray requests while idle are dropped
          send_item(rand_item($urandom_range(1) ? sfpe_pkg::OpProgData
                                                : sfpe_pkg::OpStatus));
        end
      endcase
    end
  endtask

  initial begin : frame_sink
    frame_t got;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) begin
        got.mosi    = rsp_if.mosi_byte;
        got.end_sel = rsp_if.end_select;
        got.reply   = rsp_if.reply_expected;
        got.done    = rsp_if.op_done;
        got.last    = rsp_if.last;
        predictor.match_frame(got);
      end
      if (hold_off > 0) begin
        hold_off--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("spi_flash_program_erase_sequencer regression: fail");
    $finish;
  end

  initial begin : stimulus
    predictor          = new(PageBytes);
    src_idle_pct       = 36;
    snk_idle_pct       = 74;
    hold_off           = 0;
    productive         = 0;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.operation   = '0;
    req_if.address     = '0;
    req_if.length      = '0;
    req_if.data_byte   = '0;
    req_if.status_byte = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // wrong state while idle
    send_item(request(sfpe_pkg::OpProgData, 24'h000000, 16'h0000, 8'hFF, 8'h00));
    send_item(request(sfpe_pkg::OpStatus, 24'hFFFFFF, 16'hFFFF, 8'h00, 8'h00));
    // erase at the top of the address space, busy twice, stray erase while polling
    send_item(request(sfpe_pkg::OpErase, 24'hFFFFFF, 16'h0000, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpStatus, 24'h000000, 16'h0000, 8'h00, 8'hFF));
    send_item(request(sfpe_pkg::OpStatus, 24'h000000, 16'h0000, 8'h00, 8'h01));
    send_item(request(sfpe_pkg::OpErase, 24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpStatus, 24'h000000, 16'h0000, 8'h00, 8'hFE));
    // zero length program goes straight to polling
    send_item(request(sfpe_pkg::OpProgStart, 24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpStatus, 24'h000000, 16'h0000, 8'h00, 8'h00));
    // huge length at the last byte of a page clips to one, surplus byte dropped
    send_item(request(sfpe_pkg::OpProgStart, 24'h0000FF, 16'hFFFF, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpProgData, 24'h000000, 16'h0000, 8'hFF, 8'h00));
    send_item(request(sfpe_pkg::OpProgData, 24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpStatus, 24'h000000, 16'h0000, 8'h00, 8'h00));
    // three byte program with stray requests in the data stream
    send_item(request(sfpe_pkg::OpProgStart, 24'hABCD00, 16'h0003, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpProgData, 24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpErase, 24'h123456, 16'h0000, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpStatus, 24'h000000, 16'h0000, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpProgStart, 24'h000000, 16'h0010, 8'h00, 8'h00));
    send_item(request(sfpe_pkg::OpProgData, 24'h000000, 16'h0000, 8'hA5, 8'h00));
    send_item(request(sfpe_pkg::OpProgData, 24'h000000, 16'h0000, 8'h5A, 8'h00));
    send_item(request(sfpe_pkg::OpStatus, 24'h000000, 16'h0000, 8'h00, 8'h03));
    send_item(request(sfpe_pkg::OpStatus, 24'h000000, 16'h0000, 8'h00, 8'h00));

    random_round(36, 74);
    random_round(74, 36);
    // long receiver hold-off so the block backs up into its input
    hold_off = HoldOff;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_program({8'($urandom), 8'($urandom), 8'h00}, 16'($urandom_range(16, 32)));
    random_round(0, 0);

    req_if.valid <= 1'b0;
    while (predictor.frames_due.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (predictor.errors == 0) begin
      $display("spi_flash_program_erase_sequencer regression: pass");
    end else begin
      $display("spi_flash_program_erase_sequencer regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
sv/sfpe_pkg.sv
sv/sfpe_if.sv
sv/sfpe_page_rem.sv
sv/sfpe_decode.sv
sv/sfpe_burst.sv
sv/spi_flash_program_erase_sequencer.sv
tb/spi_flash_program_erase_sequencer_test.sv
